@@ src/multi_led_blink_controller_defines.svh @@
// Assertion macros shared by the blink controller RTL.
`ifndef MULTI_LED_BLINK_CONTROLLER_DEFINES_SVH
`define MULTI_LED_BLINK_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MLBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MLBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mlbc_pkg.sv @@
// Shared widths and codes for the multi-LED blink controller.
package mlbc_pkg;

    localparam int IDX_W   = 3;
    localparam int TIME_W  = 8;
    localparam int MASK_W  = 5;
    localparam int TICK_W  = 32;

    localparam int LED_COUNT_DEFAULT = 5;

    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_PROGRAM = 1'b1;

endpackage

@@ src/mlbc_item_if.sv @@
// Input and result channel interfaces of the multi-LED blink controller.
interface mlbc_item_if import mlbc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [IDX_W-1:0]  led_index;
    logic [TIME_W-1:0] on_ticks;
    logic [TIME_W-1:0] off_ticks;
    logic [TIME_W-1:0] flash_count;
    logic              start_level;

    modport source (
        output valid, func, led_index, on_ticks, off_ticks, flash_count, start_level,
        input  ready
    );
    modport sink (
        input  valid, func, led_index, on_ticks, off_ticks, flash_count, start_level,
        output ready
    );
endinterface

interface mlbc_result_if import mlbc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] lit_mask;
    logic [TICK_W-1:0] tick_total;

    modport source (output valid, lit_mask, tick_total, input ready);
    modport sink   (input valid, lit_mask, tick_total, output ready);
endinterface

@@ src/multi_led_blink_controller.sv @@
// Multi-LED blink controller: LED_COUNT LEDs, each with its own on/off timer and flash
// budget. Every accepted item (tick or program write) produces exactly one result the next
// cycle, with the lit mask of LEDs 0-4 and the tick count since reset. The block takes one
// item per clock unless held: all LED lanes update in parallel in a single register stage,
// and that lane-state register doubles as the result register, so a new item is accepted
// in the same cycle the previous result is transferred. No clearing pass follows reset.
`include "multi_led_blink_controller_defines.svh"

module multi_led_blink_controller import mlbc_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mlbc_item_if.sink     i_item,
    mlbc_result_if.source o_result
);

    // Lane state.
    logic [LED_COUNT-1:0] r_enable, n_enable;
    logic [LED_COUNT-1:0] r_lit,    n_lit;
    logic [LED_COUNT-1:0] r_level,  n_level;
    logic [TIME_W-1:0]    r_timer   [LED_COUNT];
    logic [TIME_W-1:0]    n_timer   [LED_COUNT];
    logic [TIME_W-1:0]    r_on_rel  [LED_COUNT];
    logic [TIME_W-1:0]    n_on_rel  [LED_COUNT];
    logic [TIME_W-1:0]    r_off_rel [LED_COUNT];
    logic [TIME_W-1:0]    n_off_rel [LED_COUNT];
    logic [TIME_W-1:0]    r_flashes [LED_COUNT];
    logic [TIME_W-1:0]    n_flashes [LED_COUNT];

    logic [TICK_W-1:0]    r_tick, n_tick;
    logic                 r_out_valid, n_out_valid;
    logic                 w_accept;
    logic                 w_is_tick;
    logic                 w_steady_off;
    logic                 w_steady_on;
    logic [MASK_W-1:0]    w_mask;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_is_tick    = (i_item.func == FUNC_TICK);

    assign w_steady_off = (i_item.on_ticks == '0) && (i_item.off_ticks != '0);
    assign w_steady_on  = (i_item.on_ticks != '0) && (i_item.off_ticks == '0);

    always_comb begin
        n_enable = r_enable;
        n_lit    = r_lit;
        n_level  = r_level;
        n_tick   = r_tick;
        for (int i = 0; i < LED_COUNT; i++) begin
            n_timer[i]   = r_timer[i];
            n_on_rel[i]  = r_on_rel[i];
            n_off_rel[i] = r_off_rel[i];
            n_flashes[i] = r_flashes[i];
        end

        if (w_accept && w_is_tick) begin
            n_tick = r_tick + TICK_W'(1);
        end

        for (int i = 0; i < LED_COUNT; i++) begin
            if (w_accept && !w_is_tick) begin
                // Lanes beyond what the index can address are never programmed.
                if ((i < (2 ** IDX_W)) && (i_item.led_index == IDX_W'(i))) begin
                    if (w_steady_off) begin
                        n_enable[i] = 1'b0;
                        n_lit[i]    = 1'b0;
                    end else if (w_steady_on) begin
                        n_enable[i] = 1'b0;
                        n_lit[i]    = 1'b1;
                    end else begin
                        n_timer[i]   = i_item.on_ticks;
                        n_on_rel[i]  = i_item.on_ticks;
                        n_off_rel[i] = i_item.off_ticks;
                        n_flashes[i] = i_item.flash_count;
                        n_level[i]   = i_item.start_level;
                        n_enable[i]  = 1'b1;
                        n_lit[i]     = 1'b1;
                    end
                end
            end else if (w_accept && r_enable[i]) begin
                if (r_timer[i] == TIME_W'(1)) begin
                    n_timer[i] = r_level[i] ? r_off_rel[i] : r_on_rel[i];
                    n_lit[i]   = !r_level[i];
                    n_level[i] = !r_level[i];
                    // A flash budget of zero means the LED blinks forever.
                    if (r_flashes[i] == TIME_W'(1)) begin
                        n_enable[i] = 1'b0;
                    end else if (r_flashes[i] != '0) begin
                        n_flashes[i] = r_flashes[i] - TIME_W'(1);
                    end
                end else begin
                    n_timer[i] = r_timer[i] - TIME_W'(1);
                end
            end
        end

        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= '0;
            r_lit       <= '0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_enable    <= n_enable;
            r_lit       <= n_lit;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
        end
    end

    // Timers, reloads and phase are only read once a program write has loaded them.
    always_ff @(posedge i_clk) begin
        r_level <= n_level;
        for (int i = 0; i < LED_COUNT; i++) begin
            r_timer[i]   <= n_timer[i];
            r_on_rel[i]  <= n_on_rel[i];
            r_off_rel[i] <= n_off_rel[i];
            r_flashes[i] <= n_flashes[i];
        end
    end

    for (genvar b = 0; b < MASK_W; b++) begin : g_mask
        if (b < LED_COUNT) begin : g_led
            assign w_mask[b] = r_lit[b];
        end else begin : g_none
            assign w_mask[b] = 1'b0;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.lit_mask   = w_mask;
    assign o_result.tick_total = r_tick;

    `MLBC_ASSERT_NEXT(a_result_follows_accept, w_accept, r_out_valid,
        "accepted item did not produce a result")
    `MLBC_ASSERT_NEXT(a_tick_counts_up, w_accept && w_is_tick,
        r_tick == $past(r_tick) + TICK_W'(1), "tick count did not advance by one")
    `MLBC_ASSERT_NEXT(a_state_holds_when_idle, !w_accept,
        $stable(r_lit) && $stable(r_tick), "LED state changed without a transfer")
    `MLBC_ASSERT_NOW(a_accept_when_free, !r_out_valid, i_item.ready,
        "input stalled while no result was pending")

endmodule
